// File: hdl/qmvn_pkg.sv
// qmvn_pkg: shared constants, codes, types and a saturating add for the quad mesh vertex normal unit.
// Used by quad_mesh_vertex_normals_unit, qmvn_checker and the bench.
`default_nettype none
package qmvn_pkg;

  localparam int IDX_BITS     = 10;
  localparam int NUM_VERTICES = 1 << IDX_BITS;
  localparam int COORD_BITS   = 16;
  localparam int ACC_BITS     = 40;
  localparam int CORNERS      = 4;
  localparam int EDGE_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * EDGE_BITS;
  localparam int FN_BITS      = PROD_BITS + 1;
  localparam int MUL_BITS     = 32;
  localparam int NORM_LO_BIT  = 29;
  localparam int NORM_HI_BIT  = 30;
  localparam int MAGN_BITS    = NORM_HI_BIT + 1;
  localparam int SQ_BITS      = 64;
  localparam int LEN_BITS     = 31;
  localparam int OUT_BITS     = 16;
  localparam int FRAC_BITS    = 14;
  localparam int NUM_BITS     = MAGN_BITS + FRAC_BITS + 2;
  localparam int QUO_BITS     = 16;
  localparam int CNT_BITS     = IDX_BITS;
  localparam int OUT_UNIT     = 1 << FRAC_BITS;

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_FACE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_F_RD0,
    ST_F_RD1,
    ST_F_RD2,
    ST_F_EDGE,
    ST_F_MUL,
    ST_A_RD,
    ST_A_WR,
    ST_N_RD,
    ST_N_MAG,
    ST_N_MAX,
    ST_N_SHIFT,
    ST_N_SQ,
    ST_N_SQRT,
    ST_N_DLOAD,
    ST_N_DSTEP,
    ST_N_DONE
  } state_t;

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0] acc,
    input logic signed [FN_BITS-1:0]  n
  );
    logic signed [ACC_BITS:0] s;
    s = $signed({acc[ACC_BITS-1], acc}) + (ACC_BITS + 1)'(n);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      sat_add = s[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
    end else begin
      sat_add = s[ACC_BITS-1:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/qmvn_ram.sv
// qmvn_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module qmvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: hdl/quad_mesh_vertex_normals_unit.sv
// Quad mesh vertex normal unit: top level with sequencer and shared datapath.
// Depends on qmvn_pkg and qmvn_ram.
//
// Usage:
//   Input channel in_*: one request per accepted edge (in_valid high, in_stall low).
//   A store request writes a vertex position and zeroes its accumulator as it is accepted.
//   A face request reads three positions, forms the cross product over six passes
//   of the shared multiplier, then updates four accumulators one after another.
//   In a read request the normalising shift moves one bit a cycle, the square root
//   retires one result bit a cycle, and each of the three divisions retires one
//   quotient bit a cycle; a zero accumulator skips these steps.
//   in_stall stays high while a request is being worked on.
//   Output channel out_*: only read requests produce a result. It waits in an
//   output register while out_stall is high; a new request is still accepted, and
//   a read that finishes behind a stalled result holds until the register frees.
//   cfg_wr_en/cfg_wr_data write the winding bit at any edge; write only when idle.
//   Reset: synchronous, active low. Afterwards every accumulator entry is cleared,
//   one entry a cycle, with in_stall high throughout.
`default_nettype none
module quad_mesh_vertex_normals_unit
  import qmvn_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_cmd,
  input  wire logic [IDX_BITS-1:0]    in_vertex_index,
  input  wire logic signed [15:0]     in_pos_x,
  input  wire logic signed [15:0]     in_pos_y,
  input  wire logic signed [15:0]     in_pos_z,
  input  wire logic [IDX_BITS-1:0]    in_corner_zero,
  input  wire logic [IDX_BITS-1:0]    in_corner_one,
  input  wire logic [IDX_BITS-1:0]    in_corner_two,
  input  wire logic [IDX_BITS-1:0]    in_corner_three,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [OUT_BITS-1:0]  out_normal_x,
  output logic signed [OUT_BITS-1:0]  out_normal_y,
  output logic signed [OUT_BITS-1:0]  out_normal_z,
  output logic                        out_zero_length,
  input  wire logic                   cfg_wr_en,
  input  wire logic                   cfg_wr_data
);

  state_t                      state_r, state_nxt;
  logic [CNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic [1:0]                  comp_r, comp_nxt;
  logic                        ccw_r;
  logic                        out_valid_r;
  logic                        in_accept;
  logic                        out_load;

  logic [IDX_BITS-1:0]         vidx_r;
  logic [IDX_BITS-1:0]         corner_r [CORNERS];

  logic [3*COORD_BITS-1:0]     pos_rd_data;
  logic [IDX_BITS-1:0]         pos_rd_addr;
  logic signed [COORD_BITS-1:0] pos_c [3];
  logic signed [COORD_BITS-1:0] p0_r [3];
  logic signed [EDGE_BITS-1:0] ea_r [3];
  logic signed [EDGE_BITS-1:0] eb_r [3];
  logic signed [FN_BITS-1:0]   fn_r [3];

  logic                        acc_wr_en;
  logic [IDX_BITS-1:0]         acc_wr_addr;
  logic [3*ACC_BITS-1:0]       acc_wr_data;
  logic [IDX_BITS-1:0]         acc_rd_addr;
  logic [3*ACC_BITS-1:0]       acc_rd_data;
  logic signed [ACC_BITS-1:0]  acc_c [3];

  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [2*MUL_BITS-1:0] prod_r;
  logic signed [FN_BITS-1:0]   term;
  logic [1:0]                  fn_sel;
  logic [1:0]                  sq_sel;

  logic [ACC_BITS-1:0]         mag_r [3];
  logic                        sign_r [3];
  logic [ACC_BITS-1:0]         m_r;
  logic [ACC_BITS-1:0]         m_comb;
  logic                        zero_r;

  logic [SQ_BITS-1:0]          sum_r;
  logic [SQ_BITS-1:0]          v_r, res_r, bit_r;
  logic [SQ_BITS-1:0]          trial;

  logic [NUM_BITS-1:0]         rem_r, dd_r;
  logic [QUO_BITS-1:0]         q_r;
  logic                        qb;
  logic [QUO_BITS-1:0]         q_fin;
  logic [OUT_BITS-1:0]         nq_r [3];

  logic signed [OUT_BITS-1:0]  out_x_r, out_y_r, out_z_r;
  logic                        out_zero_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && (state_r == ST_IDLE);

  qmvn_ram #(.WIDTH(3*COORD_BITS), .DEPTH(NUM_VERTICES)) u_pos_ram (
    .clk     (clk),
    .wr_en   (in_accept && (cmd_t'(in_cmd) == CMD_STORE)),
    .wr_addr (in_vertex_index),
    .wr_data ({in_pos_x, in_pos_y, in_pos_z}),
    .rd_addr (pos_rd_addr),
    .rd_data (pos_rd_data)
  );

  qmvn_ram #(.WIDTH(3*ACC_BITS), .DEPTH(NUM_VERTICES)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_wr_en),
    .wr_addr (acc_wr_addr),
    .wr_data (acc_wr_data),
    .rd_addr (acc_rd_addr),
    .rd_data (acc_rd_data)
  );

  assign pos_c[0] = $signed(pos_rd_data[3*COORD_BITS-1:2*COORD_BITS]);
  assign pos_c[1] = $signed(pos_rd_data[2*COORD_BITS-1:COORD_BITS]);
  assign pos_c[2] = $signed(pos_rd_data[COORD_BITS-1:0]);
  assign acc_c[0] = $signed(acc_rd_data[3*ACC_BITS-1:2*ACC_BITS]);
  assign acc_c[1] = $signed(acc_rd_data[2*ACC_BITS-1:ACC_BITS]);
  assign acc_c[2] = $signed(acc_rd_data[ACC_BITS-1:0]);

  always_comb begin
    unique case (state_r)
      ST_F_RD1: pos_rd_addr = corner_r[1];
      ST_F_RD2: pos_rd_addr = corner_r[2];
      default:  pos_rd_addr = corner_r[0];
    endcase
  end

  assign acc_rd_addr = (state_r == ST_N_RD) ? vidx_r : corner_r[comp_r];

  always_comb begin
    acc_wr_en   = 1'b0;
    acc_wr_addr = corner_r[comp_r];
    acc_wr_data = '0;
    priority if (state_r == ST_CLEAR) begin
      acc_wr_en   = 1'b1;
      acc_wr_addr = cnt_r[IDX_BITS-1:0];
    end else if (in_accept && (cmd_t'(in_cmd) == CMD_STORE)) begin
      acc_wr_en   = 1'b1;
      acc_wr_addr = in_vertex_index;
    end else if (state_r == ST_A_WR) begin
      acc_wr_en   = 1'b1;
      acc_wr_data = {sat_add(acc_c[0], fn_r[0]), sat_add(acc_c[1], fn_r[1]),
                     sat_add(acc_c[2], fn_r[2])};
    end else begin
      acc_wr_en = 1'b0;
    end
  end

  // shared multiplier operand select
  assign sq_sel = (cnt_r[1:0] == 2'd3) ? 2'd0 : cnt_r[1:0];
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_N_SQ) begin
      mul_a = MUL_BITS'(mag_r[sq_sel][MAGN_BITS-1:0]);
      mul_b = MUL_BITS'(mag_r[sq_sel][MAGN_BITS-1:0]);
    end else begin
      unique case (cnt_r[2:0])
        3'd0:    begin mul_a = MUL_BITS'(ea_r[1]); mul_b = MUL_BITS'(eb_r[2]); end
        3'd1:    begin mul_a = MUL_BITS'(ea_r[2]); mul_b = MUL_BITS'(eb_r[1]); end
        3'd2:    begin mul_a = MUL_BITS'(ea_r[2]); mul_b = MUL_BITS'(eb_r[0]); end
        3'd3:    begin mul_a = MUL_BITS'(ea_r[0]); mul_b = MUL_BITS'(eb_r[2]); end
        3'd4:    begin mul_a = MUL_BITS'(ea_r[0]); mul_b = MUL_BITS'(eb_r[1]); end
        3'd5:    begin mul_a = MUL_BITS'(ea_r[1]); mul_b = MUL_BITS'(eb_r[0]); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign term   = FN_BITS'($signed(prod_r[PROD_BITS-1:0]));
  assign fn_sel = 2'((cnt_r[2:0] - 3'd1) >> 1);

  always_comb begin
    m_comb = mag_r[0];
    if (mag_r[1] > m_comb) m_comb = mag_r[1];
    if (mag_r[2] > m_comb) m_comb = mag_r[2];
  end

  assign trial = res_r + bit_r;
  assign qb    = (rem_r >= dd_r);
  assign q_fin = {q_r[QUO_BITS-2:0], qb};

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (&cnt_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cnt_nxt  = '0;
        comp_nxt = '0;
        if (in_accept) begin
          unique case (cmd_t'(in_cmd))
            CMD_FACE:  state_nxt = ST_F_RD0;
            CMD_READ:  state_nxt = ST_N_RD;
            CMD_STORE: state_nxt = ST_IDLE;
            CMD_NONE:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_F_RD0:  state_nxt = ST_F_RD1;
      ST_F_RD1:  state_nxt = ST_F_RD2;
      ST_F_RD2:  state_nxt = ST_F_EDGE;
      ST_F_EDGE: state_nxt = ST_F_MUL;
      ST_F_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[2:0] == 3'd6) begin
          cnt_nxt   = '0;
          state_nxt = ST_A_RD;
        end
      end
      ST_A_RD: state_nxt = ST_A_WR;
      ST_A_WR: begin
        comp_nxt = comp_r + 1'b1;
        state_nxt = (comp_r == 2'(CORNERS - 1)) ? ST_IDLE : ST_A_RD;
      end
      ST_N_RD:  state_nxt = ST_N_MAG;
      ST_N_MAG: state_nxt = ST_N_MAX;
      ST_N_MAX: state_nxt = (m_comb == '0) ? ST_N_DONE : ST_N_SHIFT;
      ST_N_SHIFT: begin
        if ((m_r[ACC_BITS-1:NORM_LO_BIT] != '0) && (m_r[ACC_BITS-1:NORM_HI_BIT] == '0)) begin
          cnt_nxt   = '0;
          state_nxt = ST_N_SQ;
        end
      end
      ST_N_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt   = '0;
          state_nxt = ST_N_SQRT;
        end
      end
      ST_N_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[4:0] == 5'd31) begin
          comp_nxt  = '0;
          state_nxt = ST_N_DLOAD;
        end
      end
      ST_N_DLOAD: begin
        cnt_nxt   = '0;
        state_nxt = ST_N_DSTEP;
      end
      ST_N_DSTEP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[3:0] == 4'd15) begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = (comp_r == 2'd2) ? ST_N_DONE : ST_N_DLOAD;
        end
      end
      ST_N_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      comp_r      <= '0;
      ccw_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
      if (cfg_wr_en) ccw_r <= cfg_wr_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_accept) begin
      vidx_r      <= in_vertex_index;
      corner_r[0] <= in_corner_zero;
      corner_r[1] <= in_corner_one;
      corner_r[2] <= in_corner_two;
      corner_r[3] <= in_corner_three;
    end
    unique case (state_r)
      ST_F_RD1: begin
        for (int k = 0; k < 3; k++) p0_r[k] <= pos_c[k];
      end
      ST_F_RD2: begin
        for (int k = 0; k < 3; k++) ea_r[k] <= EDGE_BITS'(pos_c[k]) - EDGE_BITS'(p0_r[k]);
      end
      ST_F_EDGE: begin
        for (int k = 0; k < 3; k++) eb_r[k] <= EDGE_BITS'(pos_c[k]) - EDGE_BITS'(p0_r[k]);
      end
      ST_F_MUL: begin
        if (cnt_r[2:0] != 3'd0) begin
          if (cnt_r[0]) begin
            fn_r[fn_sel] <= ccw_r ? term : -term;
          end else begin
            fn_r[fn_sel] <= ccw_r ? (fn_r[fn_sel] - term) : (fn_r[fn_sel] + term);
          end
        end
      end
      ST_N_MAG: begin
        for (int k = 0; k < 3; k++) begin
          sign_r[k] <= acc_c[k][ACC_BITS-1];
          mag_r[k]  <= acc_c[k][ACC_BITS-1] ? ACC_BITS'(-acc_c[k]) : ACC_BITS'(acc_c[k]);
        end
      end
      ST_N_MAX: begin
        m_r    <= m_comb;
        zero_r <= (m_comb == '0);
        for (int k = 0; k < 3; k++) nq_r[k] <= '0;
      end
      ST_N_SHIFT: begin
        if (m_r[ACC_BITS-1:NORM_LO_BIT] == '0) begin
          m_r <= m_r << 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] << 1;
        end else if (m_r[ACC_BITS-1:NORM_HI_BIT] != '0) begin
          m_r <= m_r >> 1;
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_r[k] >> 1;
        end
      end
      ST_N_SQ: begin
        if (cnt_r[1:0] == 2'd0) begin
          sum_r <= '0;
        end else begin
          sum_r <= sum_r + SQ_BITS'(prod_r);
        end
        if (cnt_r[1:0] == 2'd3) begin
          v_r   <= sum_r + SQ_BITS'(prod_r);
          res_r <= '0;
          bit_r <= SQ_BITS'(1) << (SQ_BITS - 2);
        end
      end
      ST_N_SQRT: begin
        if (v_r >= trial) begin
          v_r   <= v_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      ST_N_DLOAD: begin
        rem_r <= (NUM_BITS'(mag_r[comp_r][MAGN_BITS-1:0]) << (FRAC_BITS + 1))
                 + NUM_BITS'(res_r[LEN_BITS-1:0]);
        dd_r  <= NUM_BITS'(res_r[LEN_BITS-1:0]) << QUO_BITS;
        q_r   <= '0;
      end
      ST_N_DSTEP: begin
        if (qb) rem_r <= rem_r - dd_r;
        dd_r <= dd_r >> 1;
        q_r  <= q_fin;
        if (cnt_r[3:0] == 4'd15) begin
          nq_r[comp_r] <= sign_r[comp_r] ? OUT_BITS'(-q_fin) : OUT_BITS'(q_fin);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_x_r    <= nq_r[0];
      out_y_r    <= nq_r[1];
      out_z_r    <= nq_r[2];
      out_zero_r <= zero_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_normal_x    = out_x_r;
  assign out_normal_y    = out_y_r;
  assign out_normal_z    = out_z_r;
  assign out_zero_length = out_zero_r;

endmodule
`default_nettype wire

// File: hdl/qmvn_checker.sv
// qmvn_checker: port-level assertions for quad_mesh_vertex_normals_unit, bound to the top.
// Depends on qmvn_pkg.
`default_nettype none
module qmvn_checker
  import qmvn_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic [1:0]            in_cmd,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic signed [OUT_BITS-1:0] out_normal_x,
  input wire logic signed [OUT_BITS-1:0] out_normal_y,
  input wire logic signed [OUT_BITS-1:0] out_normal_z,
  input wire logic                  out_zero_length
);

  localparam logic signed [OUT_BITS-1:0] UNIT_P = OUT_BITS'(OUT_UNIT);
  localparam logic signed [OUT_BITS-1:0] UNIT_N = -UNIT_P;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_normal_x)
      && $stable(out_normal_y) && $stable(out_normal_z) && $stable(out_zero_length))
    else $error("stalled result changed");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("zero-length result carries a non-zero normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= UNIT_P && out_normal_x >= UNIT_N
      && out_normal_y <= UNIT_P && out_normal_y >= UNIT_N
      && out_normal_z <= UNIT_P && out_normal_z >= UNIT_N)
    else $error("normal component outside unit range");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && cmd_t'(in_cmd) == CMD_READ |=> in_stall)
    else $error("read request did not hold the input");

  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_stall && !out_valid)
    else $error("not clearing after reset");

endmodule

bind quad_mesh_vertex_normals_unit qmvn_checker u_qmvn_checker (.*);
`default_nettype wire

// File: tb/tb_quad_mesh_vertex_normals_unit.sv
// Self-checking bench for quad_mesh_vertex_normals_unit: directed table then random
// store/face/read requests, each read checked against a table value or an in-bench normal predictor.
// Depends on qmvn_pkg and the unit's RTL.
`default_nettype none
module tb_quad_mesh_vertex_normals_unit;
  import qmvn_pkg::*;

  typedef struct {
    logic signed [15:0] nx, ny, nz;
    logic               zl;
  } normal_t;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  vi;
    logic [15:0] px, py, pz;
    logic [9:0]  c0, c1, c2, c3;
    logic        typed;
    normal_t     exp;
  } row_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic [1:0] in_cmd = 0;
  logic [9:0] in_vertex_index = 0, in_corner_zero = 0, in_corner_one = 0;
  logic [9:0] in_corner_two = 0, in_corner_three = 0;
  logic signed [15:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic out_valid, out_stall = 1;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic out_zero_length;
  logic cfg_wr_en = 0, cfg_wr_data = 0;

  quad_mesh_vertex_normals_unit DUT (.*);

  initial forever #2 clk = ~clk;

  logic signed [15:0] pos_mem [3][1024];
  logic               pos_known [1024];
  logic signed [63:0] acc_mem [3][1024];
  logic               winding;
  normal_t            pending_normals [$];
  row_t               rows [$];
  int                 errors = 0, cycles = 0;

  function automatic logic signed [63:0] acc_sat(logic signed [63:0] a, logic signed [63:0] n);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< 39) - 1;
    lo = -hi - 1;
    if (n > 0 && a > hi - n) return hi;
    if (n < 0 && a < lo - n) return lo;
    return a + n;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal(logic [9:0] v);
    normal_t res;
    logic [63:0] mg [3];
    logic [63:0] m, sum, len, q;
    res = '{0, 0, 0, 1};
    m = 0;
    for (int k = 0; k < 3; k++) begin
      mg[k] = acc_mem[k][v] < 0 ? -acc_mem[k][v] : acc_mem[k][v];
      if (mg[k] > m) m = mg[k];
    end
    if (m == 0) return res;
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int k = 0; k < 3; k++) mg[k] <<= 1;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int k = 0; k < 3; k++) mg[k] >>= 1;
    end
    sum = 0;
    for (int k = 0; k < 3; k++) sum += mg[k] * mg[k];
    len = root64(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mg[k] * 64'd32768 + len) / (2 * len);
      if (acc_mem[k][v] < 0) q = -q;
      if (k == 0) res.nx = q[15:0];
      else if (k == 1) res.ny = q[15:0];
      else res.nz = q[15:0];
    end
    res.zl = 0;
    return res;
  endfunction

  function automatic void apply_request(row_t r);
    logic signed [63:0] a [3], b [3], e1 [3], e2 [3], n [3], p0;
    logic [9:0] ix [4];
    case (r.cmd)
      CMD_STORE: begin
        pos_mem[0][r.vi] = r.px;
        pos_mem[1][r.vi] = r.py;
        pos_mem[2][r.vi] = r.pz;
        pos_known[r.vi] = 1;
        for (int k = 0; k < 3; k++) acc_mem[k][r.vi] = 0;
      end
      CMD_FACE: begin
        ix = '{r.c0, r.c1, r.c2, r.c3};
        for (int k = 0; k < 3; k++) begin
          p0 = pos_mem[k][ix[0]];
          a[k] = pos_mem[k][ix[1]] - p0;
          b[k] = pos_mem[k][ix[2]] - p0;
          e1[k] = winding ? a[k] : b[k];
          e2[k] = winding ? b[k] : a[k];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        for (int i = 0; i < 4; i++)
          for (int k = 0; k < 3; k++) acc_mem[k][ix[i]] = acc_sat(acc_mem[k][ix[i]], n[k]);
      end
      CMD_READ: pending_normals.push_back(r.typed ? r.exp : unit_normal(r.vi));
      default: ;
    endcase
  endfunction

  function automatic logic [9:0] known_vertex();
    logic [9:0] v;
    do v = 10'($urandom_range(0, 1023)); while (!pos_known[v]);
    return v;
  endfunction

  function automatic row_t blank_row(cmd_t c);
    row_t r;
    r.cmd = c;
    r.vi = 10'($urandom);
    r.px = 16'($urandom); r.py = 16'($urandom); r.pz = 16'($urandom);
    r.c0 = 10'($urandom); r.c1 = 10'($urandom);
    r.c2 = 10'($urandom); r.c3 = 10'($urandom);
    r.typed = 0;
    r.exp = '{0, 0, 0, 0};
    return r;
  endfunction

  function automatic row_t random_row();
    row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r = blank_row(CMD_STORE);
      if ($urandom_range(0, 3) != 0) r.vi = 10'($urandom_range(0, 63));
      if ($urandom_range(0, 1)) begin
        r.px = 16'($urandom_range(0, 1023) - 512);
        r.py = 16'($urandom_range(0, 1023) - 512);
        r.pz = 16'($urandom_range(0, 1023) - 512);
      end
    end else if (pick < 65) begin
      r = blank_row(CMD_FACE);
      r.c0 = known_vertex(); r.c1 = known_vertex();
      r.c2 = known_vertex(); r.c3 = known_vertex();
    end else if (pick < 97) begin
      r = blank_row(CMD_READ);
      if ($urandom_range(0, 3) != 0) r.vi = known_vertex();
    end else r = blank_row(CMD_NONE);
    return r;
  endfunction

  task automatic send(row_t r);
    int gap;
    gap = $urandom_range(0, 17) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= r.cmd;
    in_vertex_index <= r.vi;
    in_pos_x <= r.px; in_pos_y <= r.py; in_pos_z <= r.pz;
    in_corner_zero <= r.c0; in_corner_one <= r.c1;
    in_corner_two <= r.c2; in_corner_three <= r.c3;
    do @(posedge clk); while (in_stall);
    apply_request(r);
  endtask

  task automatic set_winding(logic w);
    in_valid <= 0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= w;
    @(posedge clk);
    winding = w;
    cfg_wr_en <= 0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : drain
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_normals.size() == 0) begin
          $error("unexpected result");
          errors++;
        end else begin
          normal_t e;
          e = pending_normals.pop_front();
          if (out_normal_x !== e.nx) begin
            $error("normal_x exp %0d got %0d", e.nx, out_normal_x); errors++;
          end
          if (out_normal_y !== e.ny) begin
            $error("normal_y exp %0d got %0d", e.ny, out_normal_y); errors++;
          end
          if (out_normal_z !== e.nz) begin
            $error("normal_z exp %0d got %0d", e.nz, out_normal_z); errors++;
          end
          if (out_zero_length !== e.zl) begin
            $error("zero_length exp %0d got %0d", e.zl, out_zero_length); errors++;
          end
        end
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
      end
      if (gap > 0) begin
        out_stall <= 1;
        gap--;
      end else out_stall <= 0;
    end
  end

  initial begin
    row_t r;
    winding = 1;
    for (int v = 0; v < 1024; v++) begin
      pos_known[v] = 0;
      for (int k = 0; k < 3; k++) begin
        pos_mem[k][v] = 0;
        acc_mem[k][v] = 0;
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1;

    r = blank_row(CMD_READ); r.vi = 5; r.typed = 1; r.exp = '{0, 0, 0, 1}; rows.push_back(r);
    r = blank_row(CMD_READ); r.vi = 1023; r.typed = 1; r.exp = '{0, 0, 0, 1};
    rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 0; r.px = 0; r.py = 0; r.pz = 0; rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 1; r.px = 16'sh0100; r.py = 0; r.pz = 0;
    rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 2; r.px = 0; r.py = 16'sh0100; r.pz = 0;
    rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 3; r.px = 16'sh0100; r.py = 16'sh0100; r.pz = 0;
    rows.push_back(r);
    r = blank_row(CMD_FACE); r.c0 = 0; r.c1 = 1; r.c2 = 2; r.c3 = 3; rows.push_back(r);
    r = blank_row(CMD_READ); r.vi = 0; r.typed = 1; r.exp = '{0, 0, 16384, 0};
    rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 1020; r.px = 16'sh8000; r.py = 16'sh8000;
    r.pz = 16'sh8000; rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 1021; r.px = 16'sh7FFF; r.py = 16'sh8000;
    r.pz = 16'sh7FFF; rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 1022; r.px = 16'sh8000; r.py = 16'sh7FFF;
    r.pz = 16'sh7FFF; rows.push_back(r);
    r = blank_row(CMD_STORE); r.vi = 1023; r.px = 16'sh7FFF; r.py = 16'sh7FFF;
    r.pz = 16'sh8000; rows.push_back(r);
    for (int i = 0; i < 12; i++) begin
      r = blank_row(CMD_FACE); r.c0 = 1020; r.c1 = 1021; r.c2 = 1022; r.c3 = 1020;
      rows.push_back(r);
    end
    r = blank_row(CMD_READ); r.vi = 1020; rows.push_back(r);
    r = blank_row(CMD_NONE); rows.push_back(r);
    r = blank_row(CMD_READ); r.vi = 1023; rows.push_back(r);
    r = blank_row(CMD_FACE); r.c0 = 3; r.c1 = 3; r.c2 = 3; r.c3 = 3; rows.push_back(r);
    r = blank_row(CMD_READ); r.vi = 3; rows.push_back(r);
    foreach (rows[i]) send(rows[i]);

    for (int ph = 0; ph < 4; ph++) begin
      set_winding(ph % 2);
      for (int i = 0; i < 155; i++) send(random_row());
    end
    in_valid <= 0;
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
